>>> rtl/see_pkg.sv
package see_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned LevelW     = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned StepW      = $clog2(DataW + 1);

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;

  typedef enum logic [2:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpDiv,
    OpPow
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StPop1,
    StPop2,
    StExec,
    StIter,
    StFix,
    StPush,
    StFinal,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic         load_sym;   // capture symbol, last flag and operator
    logic         push_digit; // push the digit of the captured symbol
    logic         pop_a;      // pop into first operand
    logic         pop_b;      // pop into second operand
    logic         exec_start; // set up arithmetic
    logic         exec_iter;  // one serial step
    logic         exec_fix;   // sign fix-up
    logic         push_res;   // push the result
    logic         final_pop;  // pop into the output register
    logic         clear;      // clear level and flags
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_last;
    logic iter_done;
  } status_t;

endpackage

>>> rtl/see_datapath.sv
module see_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  see_pkg::cmd_t               cmd_i,
  output see_pkg::status_t            status_o,
  input  logic [7:0]                  symbol_i,
  input  logic                        last_symbol_i,
  input  logic                        cfg_wvalid,
  input  logic                        cfg_wready,
  input  logic                        cfg_wdata,
  output logic signed [see_pkg::DataW-1:0] value_o,
  output logic                        underflow_seen_o,
  output logic                        overflow_seen_o,
  output logic                        div_zero_seen_o
);

  localparam int unsigned W = see_pkg::DataW;

  logic [W-1:0] mem_q [see_pkg::StackDepth];
  logic [W-1:0] rdata_q;

  logic [see_pkg::LevelW-1:0] level_q, level_d;
  logic [7:0]  sym_q;
  logic        last_q;
  logic        mode_q;
  logic        under_q, under_d, over_q, over_d, divz_q, divz_d;
  see_pkg::op_e op_q;

  logic [W-1:0] a_q, a_d, b_q, b_d;     // first and second pop
  logic [W-1:0] acc_q, acc_d;           // quotient or power accumulator
  logic [W-1:0] rem_q, rem_d;           // remainder or squared base
  logic [W-1:0] opd_q, opd_d;           // dividend shift or exponent
  logic [W-1:0] den_q, den_d;
  logic         neg_q, neg_d;
  logic         special_q, special_d;
  logic [see_pkg::StepW-1:0] cnt_q, cnt_d;

  logic         empty;
  logic         full;
  logic [see_pkg::PtrW-1:0] top_ptr;
  logic [W-1:0] pop_val;
  logic [W-1:0] lhs, rhs;
  logic         do_push;
  logic [W-1:0] push_val;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;
  logic [W-1:0] mul_b, mul_p;
  logic [W-1:0] sq;

  assign empty   = (level_q == '0);
  assign full    = (level_q == see_pkg::LevelW'(see_pkg::StackDepth));
  assign top_ptr = see_pkg::PtrW'(level_d - see_pkg::LevelW'(1));
  assign pop_val = empty ? '1 : rdata_q;
  assign lhs     = mode_q ? a_q : b_q;
  assign rhs     = mode_q ? b_q : a_q;

  assign status_o.is_digit  = (sym_q >= see_pkg::ChZero) && (sym_q <= see_pkg::ChNine);
  assign status_o.is_op     = (sym_q == see_pkg::ChPlus) || (sym_q == see_pkg::ChMinus) ||
                              (sym_q == see_pkg::ChStar) || (sym_q == see_pkg::ChSlash) ||
                              (sym_q == see_pkg::ChCaret);
  assign status_o.is_last   = last_q;
  assign status_o.iter_done = (cnt_q == '0);

  // combinational multipliers for power steps: running product and squared base
  assign mul_b = rem_q;
  assign mul_p = acc_q * mul_b;
  assign sq    = rem_q * rem_q;

  assign rem_sh = {rem_q[W-2:0], opd_q[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};

  // stack read port: register the entry that is on top after this cycle,
  // taking a value being pushed straight from the write data
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[see_pkg::PtrW'(level_q)] <= push_val;
      rdata_q <= push_val;
    end else begin
      rdata_q <= mem_q[top_ptr];
    end
  end

  always_comb begin
    do_push  = 1'b0;
    push_val = acc_q;
    level_d  = level_q;
    under_d  = under_q;
    over_d   = over_q;
    divz_d   = divz_q;
    a_d = a_q; b_d = b_q; acc_d = acc_q; rem_d = rem_q; opd_d = opd_q;
    den_d = den_q; neg_d = neg_q; special_d = special_q; cnt_d = cnt_q;

    if (cmd_i.push_digit || cmd_i.push_res) begin
      push_val = cmd_i.push_digit ? W'(sym_q - see_pkg::ChZero) : acc_q;
      if (full) begin
        over_d = 1'b1;
      end else begin
        do_push = 1'b1;
        level_d = level_q + see_pkg::LevelW'(1);
      end
    end
    if (cmd_i.pop_a || cmd_i.pop_b || cmd_i.final_pop) begin
      if (empty) begin
        under_d = 1'b1;
      end else begin
        level_d = level_q - see_pkg::LevelW'(1);
      end
      if (cmd_i.pop_a) a_d = pop_val;
      if (cmd_i.pop_b) b_d = pop_val;
    end
    if (cmd_i.exec_start) begin
      special_d = 1'b0;
      neg_d     = 1'b0;
      cnt_d     = '0;
      unique case (op_q)
        see_pkg::OpAdd: acc_d = lhs + rhs;
        see_pkg::OpSub: acc_d = lhs - rhs;
        see_pkg::OpMul: acc_d = lhs * rhs;
        see_pkg::OpDiv: begin
          if (rhs == '0) begin
            divz_d    = 1'b1;
            special_d = 1'b1;
            acc_d     = '0;
          end else begin
            neg_d = lhs[W-1] ^ rhs[W-1];
            opd_d = lhs[W-1] ? -lhs : lhs;
            den_d = rhs[W-1] ? -rhs : rhs;
            rem_d = '0;
            acc_d = '0;
            cnt_d = see_pkg::StepW'(W);
          end
        end
        default: begin
          if (rhs[W-1]) begin
            special_d = 1'b1;
            if (lhs == W'(1))       acc_d = W'(1);
            else if (lhs == '1)     acc_d = rhs[0] ? '1 : W'(1);
            else                    acc_d = '0;
          end else begin
            acc_d = W'(1);
            rem_d = lhs;
            opd_d = rhs;
            cnt_d = see_pkg::StepW'(W);
          end
        end
      endcase
    end
    if (cmd_i.exec_iter && (cnt_q != '0)) begin
      cnt_d = cnt_q - see_pkg::StepW'(1);
      if (op_q == see_pkg::OpDiv) begin
        opd_d = {opd_q[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem_d = trial[W-1:0];
          acc_d = {acc_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[W-2:0], 1'b0};
        end
      end else begin
        if (opd_q[0]) acc_d = mul_p;
        rem_d = sq;
        opd_d = {1'b0, opd_q[W-1:1]};
      end
    end
    if (cmd_i.exec_fix && neg_q && !special_q) begin
      acc_d = -acc_q;
    end
    if (cmd_i.clear) begin
      level_d = '0;
      under_d = 1'b0;
      over_d  = 1'b0;
      divz_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      under_q <= 1'b0;
      over_q  <= 1'b0;
      divz_q  <= 1'b0;
      mode_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      level_q <= level_d;
      under_q <= under_d;
      over_q  <= over_d;
      divz_q  <= divz_d;
      cnt_q   <= cnt_d;
      if (cfg_wvalid && cfg_wready) mode_q <= cfg_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d; rem_q <= rem_d; opd_q <= opd_d;
    den_q <= den_d; neg_q <= neg_d; special_q <= special_d;
    if (cmd_i.load_sym) begin
      sym_q  <= symbol_i;
      last_q <= last_symbol_i;
      unique case (symbol_i)
        see_pkg::ChPlus:  op_q <= see_pkg::OpAdd;
        see_pkg::ChMinus: op_q <= see_pkg::OpSub;
        see_pkg::ChStar:  op_q <= see_pkg::OpMul;
        see_pkg::ChSlash: op_q <= see_pkg::OpDiv;
        default:          op_q <= see_pkg::OpPow;
      endcase
    end
    if (cmd_i.final_pop) begin
      value_o          <= pop_val;
      // the final pop itself counts towards underflow
      underflow_seen_o <= under_q | empty;
      overflow_seen_o  <= over_q;
      div_zero_seen_o  <= divz_q;
    end
  end

endmodule

>>> rtl/see_ctrl.sv
module see_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  see_pkg::status_t   status_i,
  output see_pkg::cmd_t      cmd_o
);

  see_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      see_pkg::StIdle: if (in_valid) state_d = see_pkg::StPop1;
      see_pkg::StPop1: begin
        if (status_i.is_op)         state_d = see_pkg::StPop2;
        else if (status_i.is_last)  state_d = see_pkg::StFinal;
        else                        state_d = see_pkg::StIdle;
      end
      see_pkg::StPop2: state_d = see_pkg::StExec;
      see_pkg::StExec: state_d = see_pkg::StIter;
      see_pkg::StIter: if (status_i.iter_done) state_d = see_pkg::StFix;
      see_pkg::StFix:  state_d = see_pkg::StPush;
      see_pkg::StPush: state_d = status_i.is_last ? see_pkg::StFinal : see_pkg::StIdle;
      see_pkg::StFinal: state_d = see_pkg::StOut;
      see_pkg::StOut:  if (!out_stall) state_d = see_pkg::StIdle;
      default:         state_d = see_pkg::StIdle;
    endcase
  end

  // StPop1 doubles as digit push
  always_comb begin
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_q)
      see_pkg::StIdle: begin
        in_stall       = 1'b0;
        cmd_o.load_sym = in_valid;
      end
      see_pkg::StPop1: begin
        cmd_o.push_digit = status_i.is_digit;
        cmd_o.pop_a      = status_i.is_op;
      end
      see_pkg::StPop2: cmd_o.pop_b      = 1'b1;
      see_pkg::StExec: cmd_o.exec_start = 1'b1;
      see_pkg::StIter: cmd_o.exec_iter  = 1'b1;
      see_pkg::StFix:  cmd_o.exec_fix   = 1'b1;
      see_pkg::StPush: cmd_o.push_res   = 1'b1;
      see_pkg::StFinal: begin
        cmd_o.final_pop = 1'b1;
        cmd_o.clear     = 1'b1;
      end
      see_pkg::StOut:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= see_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/stack_expression_evaluator.sv
// A digit or ignored symbol passes StIdle and StPop1; + - * also StPop2, StExec,
// StIter, StFix and StPush; / and ^ run 32 serial steps in the shared divide/power
// unit in StIter, none when the divisor is zero or the exponent negative. The last
// symbol adds a final pop and the output transfer, held while out_stall is high.
// One symbol is worked on at a time. Reset (rst_ni low, asynchronous) empties
// the stack, clears the flags and selects postfix mode; entries are kept.
module stack_expression_evaluator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 symbol_i,
  input  logic                       last_symbol_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         value_o,
  output logic                       underflow_seen_o,
  output logic                       overflow_seen_o,
  output logic                       div_zero_seen_o,
  input  logic                       cfg_wvalid,
  output logic                       cfg_wready,
  input  logic                       cfg_wdata
);

  see_pkg::cmd_t    cmd;
  see_pkg::status_t status;

  assign cfg_wready = 1'b1;

  see_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .status_i (status),
    .cmd_o    (cmd)
  );

  see_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .symbol_i, .last_symbol_i, .cfg_wvalid, .cfg_wready, .cfg_wdata,
    .value_o, .underflow_seen_o, .overflow_seen_o, .div_zero_seen_o
  );

endmodule

>>> tb/stack_expression_evaluator_test.sv
`timescale 1ns / 1ps

module stack_expression_evaluator_test;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } symbol_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        under;
    logic        over;
    logic        divz;
  } eval_result_t;

  localparam int unsigned CycleLimit = 2000000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        symbol_i;
  logic              last_symbol_i;
  logic              out_valid;
  logic              out_stall;
  logic signed [31:0] value_o;
  logic              underflow_seen_o;
  logic              overflow_seen_o;
  logic              div_zero_seen_o;
  logic              cfg_wvalid;
  logic              cfg_wready;
  logic              cfg_wdata;

  stack_expression_evaluator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .symbol_i         (symbol_i),
    .last_symbol_i    (last_symbol_i),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .value_o          (value_o),
    .underflow_seen_o (underflow_seen_o),
    .overflow_seen_o  (overflow_seen_o),
    .div_zero_seen_o  (div_zero_seen_o),
    .cfg_wvalid       (cfg_wvalid),
    .cfg_wready       (cfg_wready),
    .cfg_wdata        (cfg_wdata)
  );

  // predictor state
  logic [31:0] pred_stack [see_pkg::StackDepth];
  int unsigned pred_level;
  logic        pred_under, pred_over, pred_divz;
  logic        pred_prefix;

  symbol_item_t pending_symbols [$];
  eval_result_t expected_results [$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  items_sent;
  int unsigned  cycle_count;
  int unsigned  in_gap;
  int unsigned  out_gap;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void push_value(logic [31:0] v);
    if (pred_level >= see_pkg::StackDepth) pred_over = 1'b1;
    else begin
      pred_stack[pred_level] = v;
      pred_level++;
    end
  endfunction

  function automatic logic [31:0] pop_value();
    if (pred_level == 0) begin
      pred_under = 1'b1;
      return 32'hFFFF_FFFF;
    end
    pred_level--;
    return pred_stack[pred_level];
  endfunction

  function automatic logic [31:0] power_of(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc;
    logic [31:0] bb;
    acc = 32'd1;
    bb = b;
    if (e[31]) begin
      if (b == 32'd1) return 32'd1;
      if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (e != 0) begin
      if (e[0]) acc = acc * bb;
      bb = bb * bb;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [31:0] quotient_of(logic [31:0] n, logic [31:0] d);
    logic [31:0] an, ad, q;
    if (d == 0) begin
      pred_divz = 1'b1;
      return 32'd0;
    end
    an = n[31] ? -n : n;
    ad = d[31] ? -d : d;
    q = an / ad;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  // work out the result of one symbol, queue it when the expression ends
  function automatic void evaluate_symbol(symbol_item_t it);
    logic [31:0] a, b, lhs, rhs, r;
    eval_result_t res;
    if (it.sym >= see_pkg::ChZero && it.sym <= see_pkg::ChNine)
      push_value(32'(it.sym - see_pkg::ChZero));
    else if (it.sym inside {see_pkg::ChPlus, see_pkg::ChMinus, see_pkg::ChStar,
                            see_pkg::ChSlash, see_pkg::ChCaret}) begin
      a = pop_value();
      b = pop_value();
      lhs = pred_prefix ? a : b;
      rhs = pred_prefix ? b : a;
      case (it.sym)
        see_pkg::ChPlus:  r = lhs + rhs;
        see_pkg::ChMinus: r = lhs - rhs;
        see_pkg::ChStar:  r = lhs * rhs;
        see_pkg::ChSlash: r = quotient_of(lhs, rhs);
        default:          r = power_of(lhs, rhs);
      endcase
      push_value(r);
    end
    if (it.last) begin
      res.value = pop_value();
      res.under = pred_under;
      res.over = pred_over;
      res.divz = pred_divz;
      expected_results.push_back(res);
      pred_level = 0;
      pred_under = 0;
      pred_over = 0;
      pred_divz = 0;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver: evaluate at acceptance so the mode in force is the one used
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        evaluate_symbol({symbol_i, last_symbol_i});
        items_sent <= items_sent + 1;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_symbols.size() != 0) begin
        in_valid <= 1'b1;
        {symbol_i, last_symbol_i} <= pending_symbols.pop_front();
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    eval_result_t got, want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got = {value_o, underflow_seen_o, overflow_seen_o, div_zero_seen_o};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected value %0d u%b o%b d%b, got %0d u%b o%b d%b",
                       $signed(want.value), want.under, want.over, want.divz,
                       $signed(got.value), got.under, got.over, got.divz);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 5))
      0: return see_pkg::ChPlus;
      1: return see_pkg::ChMinus;
      2: return see_pkg::ChStar;
      3: return see_pkg::ChSlash;
      4: return see_pkg::ChCaret;
      default: return 8'($urandom_range(see_pkg::ChZero, see_pkg::ChNine));
    endcase
  endfunction

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++)
      pending_symbols.push_back({s[i], 1'(i == s.len() - 1)});
  endtask

  // well-formed expression of random content, reversed when prefix
  task automatic queue_expression(int unsigned n_ops);
    symbol_item_t seq [$];
    int unsigned depth;
    int unsigned ops;
    depth = 0;
    ops = 0;
    while (ops < n_ops || depth > 1) begin
      if (depth < 2 || (ops < n_ops && depth < 6 && $urandom_range(0, 1))) begin
        seq.push_back({8'($urandom_range(see_pkg::ChZero, see_pkg::ChNine)), 1'b0});
        depth++;
      end else begin
        seq.push_back({random_char() == see_pkg::ChZero ? see_pkg::ChPlus : random_char(),
                       1'b0});
        if (seq[$].sym >= see_pkg::ChZero && seq[$].sym <= see_pkg::ChNine) depth++;
        else begin
          depth--;
          ops++;
        end
      end
    end
    if (pred_prefix) seq.reverse();
    seq[$].last = 1'b1;
    foreach (seq[i]) pending_symbols.push_back(seq[i]);
  endtask

  task automatic drain_and_idle();
    while (pending_symbols.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk_i);
    cfg_wvalid <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    while (!cfg_wready) @(posedge clk_i);
    cfg_wvalid <= 1'b0;
    pred_prefix = m;
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    symbol_i = '0;
    last_symbol_i = 1'b0;
    out_stall = 1'b0;
    cfg_wvalid = 1'b0;
    cfg_wdata = 1'b0;
    pred_level = 0;
    pred_under = 0;
    pred_over = 0;
    pred_divz = 0;
    pred_prefix = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    cycle_count = 0;
    in_gap = 0;
    out_gap = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: operators, empty pops, zero divisor, negative exponents, overflow
    write_mode(1'b0);
    queue_text("34+");
    queue_text("35-");
    queue_text("97*");
    queue_text("90-4/");
    queue_text("50/");
    queue_text("23^");
    queue_text("00^");
    queue_text("+");
    queue_text("9");
    queue_text("x");
    queue_text("102-^");
    queue_text("01-03-^");
    queue_text("201-^");
    pending_symbols.push_back({8'hFF, 1'b0});
    pending_symbols.push_back({8'h00, 1'b1});
    for (int i = 0; i < 34; i++) pending_symbols.push_back({see_pkg::ChNine, 1'b0});
    pending_symbols.push_back({see_pkg::ChStar, 1'b1});
    drain_and_idle();
    write_mode(1'b1);
    queue_text("/01-8");
    queue_text("^29");
    drain_and_idle();

    n = 0;
    while (items_sent < 1950) begin
      if (n % 200 == 199) begin
        drain_and_idle();
        write_mode(1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 99);
      if (r < 75) queue_expression($urandom_range(1, 4));
      else if (r < 85) begin
        // noise and broken sequences
        repeat ($urandom_range(1, 6))
          pending_symbols.push_back({8'($urandom_range(0, 255)), 1'b0});
        pending_symbols.push_back({8'($urandom_range(0, 255)), 1'b1});
      end else if (r < 90) begin
        repeat ($urandom_range(30, 36))
          pending_symbols.push_back({8'($urandom_range(see_pkg::ChZero, see_pkg::ChNine)),
                                     1'b0});
        pending_symbols.push_back({random_char(), 1'b1});
      end else begin
        repeat ($urandom_range(1, 8)) pending_symbols.push_back({random_char(), 1'b0});
        pending_symbols.push_back({random_char(), 1'b1});
      end
      n++;
      while (pending_symbols.size() > 40) @(posedge clk_i);
    end
    drain_and_idle();

    $display("Sent %0d symbols, checked %0d results in both orders", items_sent,
             results_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/see_pkg.sv
rtl/see_datapath.sv
rtl/see_ctrl.sv
rtl/stack_expression_evaluator.sv
tb/stack_expression_evaluator_test.sv
